// ===== hw/rtl/glr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Layer rotation package
// Shared constants, command and register codes and the control types that
// pass between the sequencer and the serial remainder unit.
// ----------------------------------------------------------------------------
package glr_pkg;

	localparam int ROT_W      = 30;
	localparam int CFG_DATA_W = 30;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_COUNT = 2'd2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [ROT_W-1:0] ROTATION_RESET = 30'd1;

	typedef struct packed {
		logic start;
	} mod_ctrl_t;

	typedef struct packed {
		logic done;
	} mod_stat_t;

endpackage

// ===== hw/rtl/glr_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Layer rotation request channel
// Valid/ready channel that carries one store or read request.
// ----------------------------------------------------------------------------
interface glr_cmd_if #(
	parameter int IDX_W      = 6,
	parameter int VALUE_BITS = 13
);
	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [IDX_W-1:0]      row;
	logic [IDX_W-1:0]      column;
	logic [VALUE_BITS-1:0] cell_value;

	modport source (output valid, cmd, row, column, cell_value, input ready);
	modport sink   (input valid, cmd, row, column, cell_value, output ready);
endinterface

// ===== hw/rtl/glr_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Layer rotation result channel
// Valid/ready channel that carries one read result.
// ----------------------------------------------------------------------------
interface glr_result_if #(
	parameter int VALUE_BITS = 13
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] rotated_value;
	logic                  out_of_range;

	modport source (output valid, rotated_value, out_of_range, input ready);
	modport sink   (input valid, rotated_value, out_of_range, output ready);
endinterface

// ===== hw/rtl/glr_mod_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial remainder unit
// Reduces the rotation count modulo the ring perimeter, one dividend bit
// per cycle with a single compare and subtract.
// ----------------------------------------------------------------------------
module glr_mod_unit #(
	parameter int PER_W = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  glr_pkg::mod_ctrl_t      ctrl,
	input  logic [glr_pkg::ROT_W-1:0] dividend,
	input  logic [PER_W-1:0]        divisor,
	output glr_pkg::mod_stat_t      stat,
	output logic [PER_W-1:0]        remainder
);

	localparam int CNT_W = $clog2(glr_pkg::ROT_W + 1);

	logic [glr_pkg::ROT_W-1:0] dvd_q;
	logic [PER_W-1:0]          rem_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [PER_W:0]            trial;
	logic [PER_W:0]            diff;
	logic                      fits;

	assign trial = {rem_q, dvd_q[glr_pkg::ROT_W-1]};
	assign fits  = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(glr_pkg::ROT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= fits ? diff[PER_W-1:0] : trial[PER_W-1:0];
		end
	end

	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/glr_grid_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid store
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module glr_grid_mem #(
	parameter int DEPTH  = 4096,
	parameter int DATA_W = 13
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/grid_layer_rotation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid layer rotation
// Stores a grid of values and returns, for a read request, the value that
// lands at a cell after every concentric layer is rotated counter-clockwise.
// ----------------------------------------------------------------------------
// Requests arrive on cmd_ch. A store request gives no result. A read
// request gives exactly one result on result_ch. Configuration is written
// through cfg_we, cfg_index and cfg_data; the user must write it only while
// the block is idle, which the block itself does not enforce. An index
// beyond the rotation count is ignored. A read of a cell inside a full layer
// passes S_GEOM, S_LAYER, S_POS, S_MOD, S_ADD, S_SRC, S_RD and S_DONE, and
// waits in S_MOD on the bit-serial remainder of the rotation count by the
// ring perimeter. A cell on an unrotated middle line goes from S_GEOM to
// S_RD, and a read outside the configured size goes straight to S_DONE.
// Store requests are taken one every cycle while the sequencer is idle.
// cmd_ch.ready is high only while the sequencer is idle, so one request is
// in work at a time. A finished result sits in an output register; the next
// request is taken while it waits, and that request's result waits in turn
// until the receiver has taken the earlier one.
// Reset clears the sequencer, the output valid flag and the configuration
// (2 by 2 grid, rotation of one step). The grid store is not cleared; a
// cell must be stored before it is read.
// ----------------------------------------------------------------------------
module grid_layer_rotation #(
	parameter int MAX_DIM    = 64,
	parameter int VALUE_BITS = 13
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [glr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [glr_pkg::CFG_DATA_W-1:0]  cfg_data,
	glr_cmd_if.sink                         cmd_ch,
	glr_result_if.source                    result_ch
);

	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int SIZE_W = $clog2(MAX_DIM + 1);
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PER_W  = $clog2(4 * MAX_DIM - 3);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_GEOM  = 9'b000000010,
		S_LAYER = 9'b000000100,
		S_POS   = 9'b000001000,
		S_MOD   = 9'b000010000,
		S_ADD   = 9'b000100000,
		S_SRC   = 9'b001000000,
		S_RD    = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		if (v < SIZE_W'(2)) begin
			return SIZE_W'(2);
		end else if (v > SIZE_W'(MAX_DIM)) begin
			return SIZE_W'(MAX_DIM);
		end
		return v;
	endfunction

	state_t state_q;

	logic [SIZE_W-1:0]        row_count_q;
	logic [SIZE_W-1:0]        column_count_q;
	logic [glr_pkg::ROT_W-1:0] rotation_count_q;

	logic [IDX_W-1:0]  row_q, col_q, d_q, bottom_q, right_q, hm1_q, wm1_q;
	logic [IDX_W-1:0]  src_row_q, src_col_q;
	logic [SIZE_W-1:0] m_q, n_q;
	logic [PER_W-1:0]  per_q, p_q, t2_q, t3_q, q_q;
	logic              oor_q;

	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic                  out_oor_q;

	logic [SIZE_W-1:0] m_in, n_in;
	logic              in_fire, out_fire, in_oor, wr_inside;
	logic [IDX_W-1:0]  down_r, left_c, d_min, d_sel;
	logic [SIZE_W-1:0] half_min;
	logic              is_middle;
	logic [SIZE_W-1:0] hm1_w, wm1_w;
	logic [PER_W-1:0]  t2_w, t3_w, p_w;
	logic [PER_W:0]    sum_w, wrap_w;
	logic [PER_W-1:0]  sel_q_w, a_w, b_w, c_w;
	logic [IDX_W-1:0]  src_r_w, src_c_w;
	logic              load_out;

	glr_pkg::mod_ctrl_t mod_ctrl;
	glr_pkg::mod_stat_t mod_stat;
	logic [PER_W-1:0]   mod_rem;

	logic                  mem_we, mem_re;
	logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
	logic [VALUE_BITS-1:0] mem_rdata;

	assign cmd_ch.ready = (state_q == S_IDLE);
	assign in_fire      = cmd_ch.valid && cmd_ch.ready;
	assign out_fire     = result_ch.valid && result_ch.ready;

	assign m_in   = clamp_size(row_count_q);
	assign n_in   = clamp_size(column_count_q);
	assign in_oor = (SIZE_W'(cmd_ch.row) >= m_in) || (SIZE_W'(cmd_ch.column) >= n_in);

	assign wr_inside = (SIZE_W'(cmd_ch.row) < SIZE_W'(MAX_DIM))
		&& (SIZE_W'(cmd_ch.column) < SIZE_W'(MAX_DIM));
	assign mem_we    = in_fire && (cmd_ch.cmd == glr_pkg::CMD_WRITE) && wr_inside;
	assign mem_waddr = ADDR_W'(cmd_ch.row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd_ch.column);

	// Layer index: distance to the nearest edge.
	assign down_r   = IDX_W'(m_q - SIZE_W'(1) - SIZE_W'(row_q));
	assign left_c   = IDX_W'(n_q - SIZE_W'(1) - SIZE_W'(col_q));
	assign d_min    = (row_q < col_q) ? row_q : col_q;
	assign d_sel    = (down_r < left_c) ? ((d_min < down_r) ? d_min : down_r)
		: ((d_min < left_c) ? d_min : left_c);
	assign half_min = ((m_q < n_q) ? m_q : n_q) >> 1;
	assign is_middle = SIZE_W'(d_sel) >= half_min;

	assign hm1_w = m_q - SIZE_W'(1) - (SIZE_W'(d_q) << 1);
	assign wm1_w = n_q - SIZE_W'(1) - (SIZE_W'(d_q) << 1);

	assign t2_w = PER_W'(wm1_q) + PER_W'(hm1_q);
	assign t3_w = t2_w + PER_W'(wm1_q);

	always_comb begin
		if (row_q == d_q) begin
			p_w = PER_W'(col_q - d_q);
		end else if (col_q == right_q) begin
			p_w = PER_W'(wm1_q) + PER_W'(row_q - d_q);
		end else if (row_q == bottom_q) begin
			p_w = t2_w + PER_W'(right_q - col_q);
		end else begin
			p_w = t3_w + PER_W'(bottom_q - row_q);
		end
	end

	assign sum_w  = {1'b0, p_q} + {1'b0, mod_rem};
	assign wrap_w = sum_w - {1'b0, per_q};
	assign sel_q_w = (sum_w >= {1'b0, per_q}) ? wrap_w[PER_W-1:0] : sum_w[PER_W-1:0];

	assign a_w = q_q - PER_W'(wm1_q);
	assign b_w = q_q - t2_q;
	assign c_w = q_q - t3_q;

	always_comb begin
		if (q_q < PER_W'(wm1_q)) begin
			src_r_w = d_q;
			src_c_w = IDX_W'(PER_W'(d_q) + q_q);
		end else if (q_q < t2_q) begin
			src_r_w = IDX_W'(PER_W'(d_q) + a_w);
			src_c_w = right_q;
		end else if (q_q < t3_q) begin
			src_r_w = bottom_q;
			src_c_w = IDX_W'(PER_W'(right_q) - b_w);
		end else begin
			src_r_w = IDX_W'(PER_W'(bottom_q) - c_w);
			src_c_w = d_q;
		end
	end

	assign mod_ctrl.start = (state_q == S_POS);
	assign mem_re    = (state_q == S_RD);
	assign mem_raddr = ADDR_W'(src_row_q) * ADDR_W'(MAX_DIM) + ADDR_W'(src_col_q);
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || result_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q      <= SIZE_W'(2);
			column_count_q   <= SIZE_W'(2);
			rotation_count_q <= glr_pkg::ROTATION_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				glr_pkg::CFG_ROW_COUNT: begin
					row_count_q <= cfg_data[SIZE_W-1:0];
				end
				glr_pkg::CFG_COLUMN_COUNT: begin
					column_count_q <= cfg_data[SIZE_W-1:0];
				end
				glr_pkg::CFG_ROTATION_COUNT: begin
					rotation_count_q <= cfg_data[glr_pkg::ROT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire && (cmd_ch.cmd == glr_pkg::CMD_READ)) begin
						state_q <= in_oor ? S_DONE : S_GEOM;
					end
				end
				S_GEOM: begin
					state_q <= is_middle ? S_RD : S_LAYER;
				end
				S_LAYER: begin
					state_q <= S_POS;
				end
				S_POS: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (mod_stat.done) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					state_q <= S_SRC;
				end
				S_SRC: begin
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				row_q <= cmd_ch.row;
				col_q <= cmd_ch.column;
				m_q   <= m_in;
				n_q   <= n_in;
				oor_q <= in_oor;
			end
			S_GEOM: begin
				d_q       <= d_sel;
				src_row_q <= row_q;
				src_col_q <= col_q;
			end
			S_LAYER: begin
				hm1_q    <= IDX_W'(hm1_w);
				wm1_q    <= IDX_W'(wm1_w);
				bottom_q <= IDX_W'(m_q - SIZE_W'(1) - SIZE_W'(d_q));
				right_q  <= IDX_W'(n_q - SIZE_W'(1) - SIZE_W'(d_q));
				per_q    <= (PER_W'(hm1_w) + PER_W'(wm1_w)) << 1;
			end
			S_POS: begin
				p_q  <= p_w;
				t2_q <= t2_w;
				t3_q <= t3_w;
			end
			S_ADD: begin
				q_q <= sel_q_w;
			end
			S_SRC: begin
				src_row_q <= src_r_w;
				src_col_q <= src_c_w;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= oor_q ? '0 : mem_rdata;
			out_oor_q   <= oor_q;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.rotated_value = out_value_q;
	assign result_ch.out_of_range  = out_oor_q;

	glr_mod_unit #(
		.PER_W(PER_W)
	) u_mod_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mod_ctrl),
		.dividend (rotation_count_q),
		.divisor  (per_q),
		.stat     (mod_stat),
		.remainder(mod_rem)
	);

	glr_grid_mem #(
		.DEPTH (DEPTH),
		.DATA_W(VALUE_BITS)
	) u_grid_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(cmd_ch.cell_value),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

// ===== hw/rtl/glr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Layer rotation checker
// Port-level properties of the rotation block, bound to the top level.
// ----------------------------------------------------------------------------
module glr_checker #(
	parameter int VALUE_BITS = 13
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  in_cmd,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [VALUE_BITS-1:0] out_value,
	input logic                  out_oor
);

	a_read_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_cmd == glr_pkg::CMD_READ)) |=> !in_ready)
		else $error("request taken while a read is in work");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_cmd == glr_pkg::CMD_WRITE) && !out_valid)
		|=> !out_valid)
		else $error("store request produced a result");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_oor) |-> (out_value == '0))
		else $error("flagged result carries a non-zero value");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_value) && $stable(out_oor)))
		else $error("stalled result changed");

endmodule

bind grid_layer_rotation glr_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_glr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (cmd_ch.valid),
	.in_ready (cmd_ch.ready),
	.in_cmd   (cmd_ch.cmd),
	.out_valid(result_ch.valid),
	.out_ready(result_ch.ready),
	.out_value(result_ch.rotated_value),
	.out_oor  (result_ch.out_of_range)
);
